// ===== rtl/scie_pkg.sv =====
package scie_pkg;

  // Opcodes, dense from zero
  localparam logic [5:0] OP_SYSCALL = 6'd0;
  localparam logic [5:0] OP_PUSHI   = 6'd1;
  localparam logic [5:0] OP_PUSH    = 6'd2;
  localparam logic [5:0] OP_POP     = 6'd3;
  localparam logic [5:0] OP_STOP    = 6'd4;
  localparam logic [5:0] OP_NOP     = 6'd5;
  localparam logic [5:0] OP_RRMOV   = 6'd6;
  localparam logic [5:0] OP_IRMOVQ  = 6'd7;
  localparam logic [5:0] OP_IRMOVD  = 6'd8;
  localparam logic [5:0] OP_IRMOVW  = 6'd9;
  localparam logic [5:0] OP_IRMOVB  = 6'd10;
  localparam logic [5:0] OP_RMMOVQ  = 6'd11;
  localparam logic [5:0] OP_RMMOVD  = 6'd12;
  localparam logic [5:0] OP_RMMOVW  = 6'd13;
  localparam logic [5:0] OP_RMMOVB  = 6'd14;
  localparam logic [5:0] OP_MRMOVQ  = 6'd15;
  localparam logic [5:0] OP_MRMOVD  = 6'd16;
  localparam logic [5:0] OP_MRMOVW  = 6'd17;
  localparam logic [5:0] OP_MRMOVB  = 6'd18;
  localparam logic [5:0] OP_ADD     = 6'd19;
  localparam logic [5:0] OP_SUB     = 6'd20;
  localparam logic [5:0] OP_MUL     = 6'd21;
  localparam logic [5:0] OP_DIV     = 6'd22;
  localparam logic [5:0] OP_AND     = 6'd23;
  localparam logic [5:0] OP_OR      = 6'd24;
  localparam logic [5:0] OP_NOT     = 6'd25;
  localparam logic [5:0] OP_XOR     = 6'd26;
  localparam logic [5:0] OP_SHL     = 6'd27;
  localparam logic [5:0] OP_SHR     = 6'd28;
  localparam logic [5:0] OP_INC     = 6'd29;
  localparam logic [5:0] OP_DEC     = 6'd30;
  localparam logic [5:0] OP_NEG     = 6'd31;
  localparam logic [5:0] OP_CMP     = 6'd32;
  localparam logic [5:0] OP_TEST    = 6'd33;
  localparam logic [5:0] OP_JMP     = 6'd34;
  localparam logic [5:0] OP_JL      = 6'd35;
  localparam logic [5:0] OP_JLE     = 6'd36;
  localparam logic [5:0] OP_JE      = 6'd37;
  localparam logic [5:0] OP_JNE     = 6'd38;
  localparam logic [5:0] OP_JG      = 6'd39;
  localparam logic [5:0] OP_JGE     = 6'd40;
  localparam logic [5:0] OP_CALL    = 6'd41;
  localparam logic [5:0] OP_RET     = 6'd42;

  // Run status codes
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_HALT = 3'd1;
  localparam logic [2:0] ST_INS  = 3'd2;
  localparam logic [2:0] ST_ADR  = 3'd3;
  localparam logic [2:0] ST_OVF  = 3'd4;
  localparam logic [2:0] ST_UNF  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;

  // Host requests
  localparam logic [1:0] REQ_NONE  = 2'd0;

  // Syscall types
  localparam logic [63:0] SYS_TEST       = 64'd0;
  localparam logic [63:0] SYS_PRINT_STR  = 64'd1;
  localparam logic [63:0] SYS_PRINT_QUAD = 64'd2;
  localparam logic [63:0] SYS_TIME       = 64'd3;

  // Configuration register indexes
  localparam logic CFG_STACK_TOP   = 1'b0;
  localparam logic CFG_STACK_LIMIT = 1'b1;

  typedef struct packed {
    logic [5:0]         mode;
    logic [7:0]         reg_byte;
    logic signed [63:0] imm;
    logic [62:0]        time_now;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [2:0]  status;
    logic [1:0]  host_request;
    logic [15:0] host_addr;
  } result_t;

endpackage

// ===== rtl/scie_ram.sv =====
module scie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/scie_div.sv =====
module scie_div import scie_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic        neg;
  logic [64:0] trial;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem, quo[63]} - {1'b0, dvs};
  assign quot  = neg ? (64'd0 - quo) : quo;

  // Restoring division on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend[63] ? (64'd0 - dividend) : dividend;
        dvs  <= divisor[63] ? (64'd0 - divisor) : divisor;
        neg  <= dividend[63] ^ divisor[63];
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/stack_cpu_instruction_executor.sv =====
// Executes one decoded instruction per transaction against a 16 x 64-bit
// register file and a byte memory, both synchronous RAMs with one write port
// and one registered read port, and returns one result per instruction. An
// instruction that only touches registers runs three register-file reads,
// decode, two write-back slots and the result; memory adds a walk over each
// byte moved (8 for a push, pop or ret, 16 for a call, 1 to 8 for a memory
// move), a multiply three partial products, a divide the serial divider, as
// the register file has one read port and the data memory moves one byte per
// cycle. A new instruction is taken once the previous one has been handed to
// the result register; the result waits there while the next one runs.
// The memory size must be a power of two; addresses wrap modulo that size.
module stack_cpu_instruction_executor import scie_pkg::*; #(
  parameter int MEM_BYTES = 65536,
  parameter int SP_INDEX  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        instr_valid,
  output logic        instr_stall,
  input  instr_t      instr,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int         AW     = $clog2(MEM_BYTES);
  localparam logic [3:0] SP_IDX = 4'(SP_INDEX);

  typedef enum logic [13:0] {
    S_IDLE = 14'd1,
    S_RA   = 14'd2,
    S_RB   = 14'd4,
    S_SP   = 14'd8,
    S_DEC  = 14'd16,
    S_MUL  = 14'd32,
    S_DIV  = 14'd64,
    S_ALUF = 14'd128,
    S_MEMR = 14'd256,
    S_POST = 14'd512,
    S_MEMW = 14'd1024,
    S_WB1  = 14'd2048,
    S_WB2  = 14'd4096,
    S_DONE = 14'd8192
  } state_t;

  typedef enum logic [1:0] {
    P_PRINT,
    P_POP,
    P_LOAD,
    P_RET
  } post_t;

  state_t        state;
  post_t         post;
  logic [5:0]    op;
  logic [3:0]    ra;
  logic [3:0]    rb;
  logic [63:0]   imm;
  logic [62:0]   tnow;
  logic [63:0]   a;
  logic [63:0]   b;
  logic [63:0]   sp;
  logic [63:0]   res;
  logic [63:0]   t;
  logic [15:0]   pc;
  logic [2:0]    run_status;
  logic          zf;
  logic          sf;
  logic          of;
  logic [16:0]   stack_top;
  logic [16:0]   stack_limit;
  logic [15:0]   rf_valid;
  logic [3:0]    rd_idx;
  logic          rd_valid;
  logic [AW-1:0] mem_base;
  logic [4:0]    mem_len;
  logic [4:0]    cnt;
  logic [127:0]  mem_wdata;
  logic          wb1_en;
  logic [63:0]   wb1_val;
  logic          wb2_en;
  logic [3:0]    wb2_idx;
  logic [63:0]   wb2_val;
  logic [15:0]   r_npc;
  logic [2:0]    r_st;
  logic [1:0]    r_req;
  logic [15:0]   r_haddr;

  logic [3:0]    rf_raddr;
  logic          rf_we;
  logic [3:0]    rf_waddr;
  logic [63:0]   rf_wdata;
  logic [63:0]   rf_rdata;
  logic [63:0]   rf_val;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_rdata;
  logic [4:0]    cnt_m1;

  logic [16:0]   sp_floor;
  logic          sp_lt8;
  logic          sp_lt16;
  logic          sp_ge_top;
  logic          ret_unf;
  logic [63:0]   maddr;
  logic [63:0]   jaddr;
  logic [63:0]   alu_r;
  logic          alu_ov;
  logic          lt;
  logic          taken;
  logic [3:0]    msz;
  logic [63:0]   irm_mask;
  logic [31:0]   mul_x;
  logic [31:0]   mul_y;
  logic [63:0]   mul_p;
  logic          div_start;
  logic          div_done;
  logic [63:0]   div_q;

  function automatic logic bad_addr(input logic [63:0] x);
    return (x == 64'd0) || (x >= 64'(MEM_BYTES));
  endfunction

  assign instr_stall = (state != S_IDLE);
  assign cfg_ready   = 1'b1;

  // Register file read address follows the read sequence
  always_comb begin
    unique case (state)
      S_IDLE:  rf_raddr = instr.reg_byte[3:0];
      S_RA:    rf_raddr = rb;
      default: rf_raddr = SP_IDX;
    endcase
  end

  // Entries never written read as their reset value
  assign rf_val = rd_valid ? rf_rdata :
                  ((rd_idx == SP_IDX) ? 64'(stack_top) : 64'd0);

  // Write-back slots
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = SP_IDX;
    rf_wdata = wb1_val;
    if (state == S_WB1) begin
      rf_we = wb1_en;
    end else if (state == S_WB2) begin
      rf_we    = wb2_en;
      rf_waddr = wb2_idx;
      rf_wdata = wb2_val;
    end
  end

  scie_ram #(.WIDTH(64), .DEPTH(16)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  // Byte memory walks one byte a cycle from the base address
  assign mem_addr = mem_base + AW'(cnt);
  assign mem_we   = (state == S_MEMW);
  assign cnt_m1   = cnt - 5'd1;

  scie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata[{cnt[3:0], 3'b000} +: 8]),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  // Stack bounds and address checks
  always_comb begin
    sp_floor  = (stack_limit >= stack_top) ? 17'd0 : (stack_top - stack_limit);
    sp_lt8    = sp < (64'(sp_floor) + 64'd8);
    sp_lt16   = sp < (64'(sp_floor) + 64'd16);
    sp_ge_top = sp >= 64'(stack_top);
    ret_unf   = sp_ge_top || ((sp + 64'd8) >= 64'(stack_top));
    maddr     = imm + b;
    jaddr     = 64'(pc) + imm;
  end

  // Combinational ALU operations
  always_comb begin
    unique case (op)
      OP_ADD:          alu_r = b + a;
      OP_SUB, OP_CMP:  alu_r = b - a;
      OP_AND:          alu_r = b & a;
      OP_OR:           alu_r = b | a;
      OP_XOR:          alu_r = b ^ a;
      OP_SHL:          alu_r = b << a[5:0];
      OP_SHR:          alu_r = $unsigned($signed(b) >>> a[5:0]);
      OP_NOT:          alu_r = ~a;
      OP_INC:          alu_r = a + 64'd1;
      OP_DEC:          alu_r = a - 64'd1;
      OP_NEG:          alu_r = 64'd0 - a;
      default:         alu_r = a;
    endcase
    if (op == OP_ADD) begin
      alu_ov = (a[63] == b[63]) && (alu_r[63] != a[63]);
    end else begin
      alu_ov = (a[63] != b[63]) && (alu_r[63] != b[63]);
    end
  end

  // Branch condition
  always_comb begin
    lt = sf ^ of;
    unique case (op)
      OP_JL:   taken = lt;
      OP_JLE:  taken = lt || zf;
      OP_JE:   taken = zf;
      OP_JNE:  taken = !zf;
      OP_JG:   taken = !lt && !zf;
      OP_JGE:  taken = !lt;
      default: taken = 1'b1;
    endcase
  end

  // Access size for sized moves
  always_comb begin
    unique case (op)
      OP_IRMOVD, OP_RMMOVD, OP_MRMOVD: begin
        msz = 4'd4;
        irm_mask = 64'h0000_0000_FFFF_FFFF;
      end
      OP_IRMOVW, OP_RMMOVW, OP_MRMOVW: begin
        msz = 4'd2;
        irm_mask = 64'h0000_0000_0000_FFFF;
      end
      OP_IRMOVB, OP_RMMOVB, OP_MRMOVB: begin
        msz = 4'd1;
        irm_mask = 64'h0000_0000_0000_00FF;
      end
      default: begin
        msz = 4'd8;
        irm_mask = '1;
      end
    endcase
  end

  // Shared 32 x 32 multiplier for the low 64 bits of the product
  assign mul_x = (cnt == 5'd1) ? a[63:32] : a[31:0];
  assign mul_y = (cnt == 5'd2) ? b[63:32] : b[31:0];
  assign mul_p = mul_x * mul_y;

  assign div_start = (state == S_DEC) && (run_status == ST_OK) && (op == OP_DIV) &&
                     (a != 64'd0);

  scie_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (b),
    .divisor  (a),
    .done     (div_done),
    .quot     (div_q)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      pc           <= '0;
      run_status   <= ST_OK;
      zf           <= 1'b0;
      sf           <= 1'b0;
      of           <= 1'b0;
      stack_top    <= 17'h10000;
      stack_limit  <= 17'h04000;
      rf_valid     <= '0;
    end else begin
      // Drop the result once taken
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      // Configuration writes; the stack pointer falls back to stack_top
      if (cfg_valid) begin
        if (cfg_index == CFG_STACK_TOP) begin
          stack_top        <= cfg_data;
          rf_valid[SP_IDX] <= 1'b0;
        end else begin
          stack_limit <= cfg_data;
        end
      end

      if (rf_we) begin
        rf_valid[rf_waddr] <= 1'b1;
      end
      rd_idx   <= rf_raddr;
      rd_valid <= rf_valid[rf_raddr];

      unique case (state)
        S_IDLE: begin
          if (instr_valid) begin
            op    <= instr.mode;
            ra    <= instr.reg_byte[3:0];
            rb    <= instr.reg_byte[7:4];
            imm   <= instr.imm;
            tnow  <= instr.time_now;
            state <= S_RA;
          end
        end

        S_RA: begin
          a     <= rf_val;
          state <= S_RB;
        end

        S_RB: begin
          b     <= rf_val;
          state <= S_SP;
        end

        S_SP: begin
          sp    <= rf_val;
          state <= S_DEC;
        end

        S_DEC: begin
          wb1_en  <= 1'b0;
          wb2_en  <= 1'b0;
          wb2_idx <= ra;
          r_req   <= REQ_NONE;
          r_haddr <= '0;
          r_st    <= ST_OK;
          r_npc   <= pc;
          cnt     <= '0;
          t       <= '0;
          state   <= S_WB1;
          if (run_status != ST_OK) begin
            r_st  <= run_status;
            state <= S_DONE;
          end else begin
            unique case (op)
              OP_SYSCALL: begin
                if (imm == SYS_TEST) begin
                  r_npc <= pc + 16'd2;
                end else if (imm == SYS_PRINT_STR || imm == SYS_PRINT_QUAD) begin
                  if (sp_ge_top) begin
                    r_st  <= ST_UNF;
                    state <= S_DONE;
                  end else begin
                    mem_base <= AW'(sp);
                    mem_len  <= 5'd8;
                    post     <= P_PRINT;
                    state    <= S_MEMR;
                  end
                end else if (imm == SYS_TIME) begin
                  wb2_en  <= 1'b1;
                  wb2_idx <= 4'd0;
                  wb2_val <= {1'b0, tnow};
                  r_npc   <= pc + 16'd2;
                end else begin
                  r_st  <= ST_INS;
                  state <= S_DONE;
                end
              end

              OP_PUSHI, OP_PUSH: begin
                if (sp_lt8) begin
                  r_st  <= ST_OVF;
                  state <= S_DONE;
                end else begin
                  mem_base  <= AW'(sp - 64'd8);
                  mem_len   <= 5'd8;
                  mem_wdata <= {64'd0, (op == OP_PUSHI) ? imm : a};
                  wb1_en    <= 1'b1;
                  wb1_val   <= sp - 64'd8;
                  r_npc     <= pc + ((op == OP_PUSHI) ? 16'd9 : 16'd2);
                  state     <= S_MEMW;
                end
              end

              OP_POP: begin
                if (sp_ge_top) begin
                  r_st  <= ST_UNF;
                  state <= S_DONE;
                end else begin
                  mem_base <= AW'(sp);
                  mem_len  <= 5'd8;
                  post     <= P_POP;
                  state    <= S_MEMR;
                end
              end

              OP_STOP: begin
                r_st  <= ST_HALT;
                r_npc <= pc + 16'd1;
                state <= S_DONE;
              end

              OP_NOP: begin
                r_npc <= pc + 16'd1;
                state <= S_DONE;
              end

              OP_RRMOV: begin
                wb2_en  <= 1'b1;
                wb2_val <= b;
                r_npc   <= pc + 16'd2;
              end

              OP_IRMOVQ, OP_IRMOVD, OP_IRMOVW, OP_IRMOVB: begin
                wb2_en  <= 1'b1;
                wb2_val <= (a & ~irm_mask) | (imm & irm_mask);
                r_npc   <= pc + 16'd2 + 16'(msz);
              end

              OP_RMMOVQ, OP_RMMOVD, OP_RMMOVW, OP_RMMOVB: begin
                if (bad_addr(maddr)) begin
                  r_st  <= ST_ADR;
                  state <= S_DONE;
                end else begin
                  mem_base  <= AW'(maddr);
                  mem_len   <= 5'(msz);
                  mem_wdata <= {64'd0, a};
                  r_npc     <= pc + 16'd10;
                  state     <= S_MEMW;
                end
              end

              OP_MRMOVQ, OP_MRMOVD, OP_MRMOVW, OP_MRMOVB: begin
                if (bad_addr(maddr)) begin
                  r_st  <= ST_ADR;
                  state <= S_DONE;
                end else begin
                  mem_base <= AW'(maddr);
                  mem_len  <= 5'(msz);
                  post     <= P_LOAD;
                  state    <= S_MEMR;
                end
              end

              OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR, OP_CMP: begin
                zf <= (alu_r == 64'd0);
                sf <= alu_r[63];
                if (op == OP_ADD || op == OP_SUB || op == OP_CMP) begin
                  of <= alu_ov;
                end
                wb2_en  <= (op != OP_CMP);
                wb2_idx <= rb;
                wb2_val <= alu_r;
                r_npc   <= pc + 16'd2;
              end

              OP_MUL: begin
                state <= S_MUL;
              end

              OP_DIV: begin
                if (a == 64'd0) begin
                  r_st  <= ST_DIV;
                  state <= S_DONE;
                end else begin
                  state <= S_DIV;
                end
              end

              OP_NOT, OP_INC, OP_DEC, OP_NEG, OP_TEST: begin
                zf      <= (alu_r == 64'd0);
                sf      <= alu_r[63];
                wb2_en  <= 1'b1;
                wb2_val <= alu_r;
                r_npc   <= pc + 16'd2;
              end

              OP_JMP, OP_JL, OP_JLE, OP_JE, OP_JNE, OP_JG, OP_JGE: begin
                state <= S_DONE;
                if (!taken) begin
                  r_npc <= pc + 16'd9;
                end else if (bad_addr(jaddr)) begin
                  r_st <= ST_ADR;
                end else begin
                  r_npc <= pc + 16'd9 + imm[15:0];
                end
              end

              OP_CALL: begin
                if (bad_addr(imm)) begin
                  r_st  <= ST_ADR;
                  state <= S_DONE;
                end else if (sp_lt16) begin
                  r_st  <= ST_OVF;
                  state <= S_DONE;
                end else begin
                  mem_base  <= AW'(sp - 64'd16);
                  mem_len   <= 5'd16;
                  mem_wdata <= {64'(pc) + 64'd9, 64'd0};
                  wb1_en    <= 1'b1;
                  wb1_val   <= sp - 64'd16;
                  r_npc     <= imm[15:0];
                  state     <= S_MEMW;
                end
              end

              OP_RET: begin
                if (ret_unf) begin
                  r_st  <= ST_UNF;
                  state <= S_DONE;
                end else begin
                  mem_base <= AW'(sp + 64'd8);
                  mem_len  <= 5'd8;
                  post     <= P_RET;
                  state    <= S_MEMR;
                end
              end

              default: begin
                r_st  <= ST_INS;
                state <= S_DONE;
              end
            endcase
          end
        end

        // Accumulate the three partial products
        S_MUL: begin
          if (cnt == 5'd0) begin
            res <= mul_p;
          end else begin
            res <= res + {mul_p[31:0], 32'd0};
          end
          if (cnt == 5'd2) begin
            state <= S_ALUF;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end

        S_DIV: begin
          if (div_done) begin
            res   <= div_q;
            state <= S_ALUF;
          end
        end

        // Flags and write-back for multiply and divide results
        S_ALUF: begin
          zf      <= (res == 64'd0);
          sf      <= res[63];
          wb2_en  <= 1'b1;
          wb2_idx <= rb;
          wb2_val <= res;
          r_npc   <= pc + 16'd2;
          state   <= S_WB1;
        end

        // Read bytes little-endian; data comes from the registered read port in the cycle after its address
        S_MEMR: begin
          if (cnt != 5'd0) begin
            t[{cnt_m1[2:0], 3'b000} +: 8] <= mem_rdata;
          end
          if (cnt == mem_len) begin
            state <= S_POST;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end

        S_POST: begin
          state <= S_WB1;
          unique case (post)
            P_PRINT: begin
              if (bad_addr(t)) begin
                r_st  <= ST_ADR;
                state <= S_DONE;
              end else begin
                wb1_en  <= 1'b1;
                wb1_val <= sp + 64'd8;
                r_req   <= imm[1:0];
                r_haddr <= t[15:0];
                r_npc   <= pc + 16'd2;
              end
            end
            P_POP: begin
              wb1_en  <= 1'b1;
              wb1_val <= sp + 64'd8;
              wb2_en  <= 1'b1;
              wb2_val <= t;
              r_npc   <= pc + 16'd2;
            end
            P_LOAD: begin
              wb2_en  <= 1'b1;
              wb2_val <= t;
              r_npc   <= pc + 16'd10;
            end
            P_RET: begin
              if (bad_addr(t)) begin
                r_st  <= ST_ADR;
                state <= S_DONE;
              end else begin
                wb1_en  <= 1'b1;
                wb1_val <= sp + 64'd16;
                r_npc   <= t[15:0];
              end
            end
          endcase
        end

        S_MEMW: begin
          if (cnt == mem_len - 5'd1) begin
            state <= S_WB1;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end

        // Stack pointer first, then the destination, so a pop into sp keeps the value
        S_WB1: begin
          state <= S_WB2;
        end

        S_WB2: begin
          state <= S_DONE;
        end

        // Hold until the result register is free, then commit pc and status
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result       <= '{next_pc: r_npc, status: r_st,
                              host_request: r_req, host_addr: r_haddr};
            result_valid <= 1'b1;
            pc           <= r_npc;
            run_status   <= r_st;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
